// ===== design/smgs_pkg.sv =====
// Shared types and constants for the staggered multivector gradient stencil.
// No dependencies.
package smgs_pkg;

    localparam int DEF_MAX_X = 64;
    localparam int DEF_MAX_Y = 64;
    localparam int DEF_MAX_Z = 64;

    localparam int DW         = 32;
    localparam int N_COMP     = 8;
    localparam int CELL_W     = DW * N_COMP;
    localparam int SIZE_W     = 7;
    localparam int CELL_IDX_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_W      = ((CELL_W + 3 * CELL_IDX_W + 7) / 8) * 8;
    localparam int PAD_W      = OUT_W - CELL_W - 3 * CELL_IDX_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_Z    = 3'd6;

    // multivector components, scalar in the lowest bits
    localparam int C_S  = 0;
    localparam int C_VX = 1;
    localparam int C_VY = 2;
    localparam int C_VZ = 3;
    localparam int C_BA = 4;
    localparam int C_BB = 5;
    localparam int C_BC = 6;
    localparam int C_PS = 7;

    // window taps read from the delay memory
    localparam int T_PX  = 0;  // lag - 1
    localparam int T_C   = 1;  // lag
    localparam int T_MX  = 2;  // lag + 1
    localparam int T_PY  = 3;  // lag - size_x, 0 in one dimension
    localparam int T_MY  = 4;  // lag + size_x
    localparam int T_MZ  = 5;  // 2 * lag
    localparam int N_TAP = 6;

    localparam int N_TERM = 3 * N_COMP;

    typedef logic signed [DW-1:0]         t_comp;
    typedef logic [N_COMP-1:0][DW-1:0]    t_cell;

endpackage

// ===== design/staggered_multivector_gradient_stencil.sv =====
// Staggered multivector gradient stencil, top level.
// Depends on smgs_pkg (cell type, register indexes, tap and component codes).
//
// channel  | dir | handshake                    | content
// ---------+-----+------------------------------+--------------------------------------
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | one grid cell, 8 x Q16.16
// m_axis   | out | m_axis_tvalid/m_axis_tready  | gradient, cell indexes, tlast=last cell
// cfg      | in  | i_cfg_valid/o_cfg_ready      | register index + 32-bit write data
//
// One cell is taken every cycle unless m_axis stalls; a result leaves after the
// cell that completes its stencil (lag 1, size_x or size_x*size_y cells behind).
// Stages: window memory read, 32x32 difference products, round/sum/saturate.
// Reset is synchronous; the window reads as zero until written (fill count), so no
// clearing pass is needed. A stall on m_axis holds every stage and the input side.
module staggered_multivector_gradient_stencil
    import smgs_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // scalar, vec_x, vec_y, vec_z, biv_a, biv_b, biv_c, pseudo (32 bits each)
    input  logic [CELL_W-1:0]    s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // grad_scalar, grad_vec_x/y/z, grad_biv_a/b/c, grad_pseudo (32 each),
    // cell_x, cell_y, cell_z (6 each), zero pad
    output logic [OUT_W-1:0]     m_axis_tdata,
    output logic                 m_axis_tlast,  // last_cell
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DW-1:0]        i_cfg_data
);

    localparam int DEPTH = 2 * MAX_X * MAX_Y + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [SIZE_W-1:0] SX_MAX = (MAX_X > 127) ? 7'd127 : SIZE_W'(MAX_X);
    localparam logic [SIZE_W-1:0] SY_MAX = (MAX_Y > 127) ? 7'd127 : SIZE_W'(MAX_Y);
    localparam logic [SIZE_W-1:0] SZ_MAX = (MAX_Z > 127) ? 7'd127 : SIZE_W'(MAX_Z);
    localparam logic [AW-1:0]     LAST_A = AW'(DEPTH - 1);

    // configuration
    logic [1:0]        r_active_dims;
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [DW-1:0]     r_inv_x, r_inv_y, r_inv_z;

    // position and window bookkeeping
    logic [SIZE_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [AW-1:0]     r_wp, r_fill;

    logic              cfg_wr, accept, en;
    logic [1:0]        nd;
    logic [SIZE_W-1:0] sx, sy, sz;
    logic [13:0]       sxy;
    logic [AW-1:0]     lag, wa;
    logic [AW-1:0]     k   [N_TAP];
    logic [AW-1:0]     ra  [N_TAP];
    logic [AW:0]       dif [N_TAP];
    logic [AW:0]       wrp [N_TAP];

    logic [SIZE_W-1:0] px, py, pz, cx, cy, cz, nx_x, nx_y, nx_z;
    logic              emit, last;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept      = s_axis_tvalid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_dims <= 2'd3;
            r_size_x      <= 7'd64;
            r_size_y      <= 7'd64;
            r_size_z      <= 7'd64;
            r_inv_x       <= 32'd65536;
            r_inv_y       <= 32'd65536;
            r_inv_z       <= 32'd65536;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_DIMS: r_active_dims <= i_cfg_data[1:0];
                CFG_SIZE_X:      r_size_x      <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:      r_size_y      <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:      r_size_z      <= i_cfg_data[SIZE_W-1:0];
                CFG_INV_DX_X:    r_inv_x       <= i_cfg_data;
                CFG_INV_DX_Y:    r_inv_y       <= i_cfg_data;
                CFG_INV_DX_Z:    r_inv_z       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry and tap offsets
    always_comb begin
        nd  = (r_active_dims == 2'd0) ? 2'd1 : r_active_dims;
        sx  = (r_size_x < 7'd3) ? 7'd3 : ((r_size_x > SX_MAX) ? SX_MAX : r_size_x);
        sy  = (r_size_y < 7'd1) ? 7'd1 : ((r_size_y > SY_MAX) ? SY_MAX : r_size_y);
        sz  = (r_size_z < 7'd1) ? 7'd1 : ((r_size_z > SZ_MAX) ? SZ_MAX : r_size_z);
        sxy = 14'(sx) * 14'(sy);
        case (nd)
            2'd1:    lag = AW'(1);
            2'd2:    lag = AW'(sx);
            default: lag = AW'(sxy);
        endcase
        k[T_PX] = lag - AW'(1);
        k[T_C]  = lag;
        k[T_MX] = lag + AW'(1);
        k[T_PY] = (nd >= 2'd2) ? lag - AW'(sx) : '0;
        k[T_MY] = lag + AW'(sx);
        k[T_MZ] = AW'({lag, 1'b0});
        wa = (r_wp == LAST_A) ? '0 : r_wp + AW'(1);
        for (int i = 0; i < N_TAP; i++) begin
            dif[i] = {1'b0, wa} - {1'b0, k[i]};
            wrp[i] = dif[i] + (AW+1)'(DEPTH);
            ra[i]  = dif[i][AW] ? wrp[i][AW-1:0] : dif[i][AW-1:0];
        end
    end

    // position of the incoming cell, emit decision, cell indexes
    always_comb begin
        if (r_pos_x >= sx || r_pos_y >= sy || r_pos_z >= sz) begin
            px = '0; py = '0; pz = '0;
        end else begin
            px = r_pos_x; py = r_pos_y; pz = r_pos_z;
        end
        cx = px; cy = py; cz = pz;
        case (nd)
            2'd1: begin
                emit = px >= 7'd2;
                cx   = (px == '0) ? px : px - 7'd1;
            end
            2'd2: begin
                emit = px >= 7'd1 && px <= sx - 7'd2 && py >= 7'd2;
                cy   = (py == '0) ? py : py - 7'd1;
            end
            default: begin
                emit = px >= 7'd1 && px <= sx - 7'd2 && py >= 7'd1 && sy >= 7'd3 &&
                       py <= sy - 7'd2 && pz >= 7'd2;
                cz   = (pz == '0) ? pz : pz - 7'd1;
            end
        endcase
        last = ({1'b0, cx} == {1'b0, sx} - 8'd2) &&
               ({1'b0, cy} == {1'b0, sy} - ((nd >= 2'd2) ? 8'd2 : 8'd1)) &&
               ({1'b0, cz} == {1'b0, sz} - ((nd == 2'd3) ? 8'd2 : 8'd1));
        nx_x = px; nx_y = py; nx_z = pz;
        if ({1'b0, px} + 8'd1 < {1'b0, sx}) begin
            nx_x = px + 7'd1;
        end else begin
            nx_x = '0;
            if ({1'b0, py} + 8'd1 < {1'b0, sy}) begin
                nx_y = py + 7'd1;
            end else begin
                nx_y = '0;
                nx_z = ({1'b0, pz} + 8'd1 < {1'b0, sz}) ? pz + 7'd1 : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
        end else begin
            // geometry writes restart the frame
            if (cfg_wr && i_cfg_index inside {CFG_ACTIVE_DIMS, CFG_SIZE_X,
                                              CFG_SIZE_Y, CFG_SIZE_Z}) begin
                r_pos_x <= '0;
                r_pos_y <= '0;
                r_pos_z <= '0;
            end else if (accept) begin
                r_pos_x <= nx_x;
                r_pos_y <= nx_y;
                r_pos_z <= nx_z;
            end
            if (accept) begin
                r_wp <= wa;
                if (r_fill != LAST_A) r_fill <= r_fill + AW'(1);
            end
        end
    end

    // ---------------- stage 1: window read ----------------
    t_cell             r_rd [N_TAP];
    t_cell             r_cur;
    logic [N_TAP-1:0]  r_byp, r_ok;
    logic              r_v1, r_last1;
    logic [CELL_IDX_W-1:0] r_cx1, r_cy1, r_cz1;

    // three copies, two read ports each
    for (genvar g = 0; g < 3; g++) begin : g_win
        logic [CELL_W-1:0] mem [DEPTH];
        always_ff @(posedge i_clk) begin
            if (accept) mem[wa] <= s_axis_tdata;
            if (en) begin
                r_rd[2*g]   <= mem[ra[2*g]];
                r_rd[2*g+1] <= mem[ra[2*g+1]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cur   <= s_axis_tdata;
            r_cx1   <= cx[CELL_IDX_W-1:0];
            r_cy1   <= cy[CELL_IDX_W-1:0];
            r_cz1   <= cz[CELL_IDX_W-1:0];
            r_last1 <= last;
            for (int i = 0; i < N_TAP; i++) begin
                r_byp[i] <= (k[i] == '0);
                r_ok[i]  <= (k[i] <= r_fill);
            end
        end
    end

    t_cell tp [N_TAP];
    t_cell w_c, w_mx, w_px, w_my, w_py, w_mz, w_pz;
    t_comp opa [N_TERM];
    t_comp opb [N_TERM];
    logic signed [DW:0] dd [N_TERM];
    logic [DW-1:0]      mag [N_TERM];
    logic [DW-1:0]      inv [3];

    always_comb begin
        for (int i = 0; i < N_TAP; i++) begin
            tp[i] = r_byp[i] ? r_cur : (r_ok[i] ? r_rd[i] : '0);
        end
        w_c  = tp[T_C];
        w_mx = tp[T_MX];
        w_px = tp[T_PX];
        w_my = tp[T_MY];
        w_py = tp[T_PY];
        w_mz = tp[T_MZ];
        w_pz = r_cur;
        // x terms
        opa[C_S]  = w_c[C_VX];  opb[C_S]  = w_mx[C_VX];
        opa[C_VX] = w_px[C_S];  opb[C_VX] = w_c[C_S];
        opa[C_VZ] = w_mx[C_BB]; opb[C_VZ] = w_c[C_BB];
        opa[C_VY] = w_c[C_BC];  opb[C_VY] = w_mx[C_BC];
        opa[C_BA] = w_c[C_PS];  opb[C_BA] = w_mx[C_PS];
        opa[C_BC] = w_px[C_VY]; opb[C_BC] = w_c[C_VY];
        opa[C_BB] = w_c[C_VZ];  opb[C_BB] = w_px[C_VZ];
        opa[C_PS] = w_px[C_BA]; opb[C_PS] = w_c[C_BA];
        // y terms
        opa[N_COMP+C_S]  = w_c[C_VY];  opb[N_COMP+C_S]  = w_my[C_VY];
        opa[N_COMP+C_VY] = w_py[C_S];  opb[N_COMP+C_VY] = w_c[C_S];
        opa[N_COMP+C_VZ] = w_c[C_BA];  opb[N_COMP+C_VZ] = w_my[C_BA];
        opa[N_COMP+C_VX] = w_my[C_BC]; opb[N_COMP+C_VX] = w_c[C_BC];
        opa[N_COMP+C_BB] = w_c[C_PS];  opb[N_COMP+C_BB] = w_my[C_PS];
        opa[N_COMP+C_BA] = w_py[C_VZ]; opb[N_COMP+C_BA] = w_c[C_VZ];
        opa[N_COMP+C_BC] = w_c[C_VX];  opb[N_COMP+C_BC] = w_py[C_VX];
        opa[N_COMP+C_PS] = w_py[C_BB]; opb[N_COMP+C_PS] = w_c[C_BB];
        // z terms
        opa[2*N_COMP+C_S]  = w_c[C_VZ];  opb[2*N_COMP+C_S]  = w_mz[C_VZ];
        opa[2*N_COMP+C_VZ] = w_pz[C_S];  opb[2*N_COMP+C_VZ] = w_c[C_S];
        opa[2*N_COMP+C_VX] = w_c[C_BB];  opb[2*N_COMP+C_VX] = w_mz[C_BB];
        opa[2*N_COMP+C_VY] = w_mz[C_BA]; opb[2*N_COMP+C_VY] = w_c[C_BA];
        opa[2*N_COMP+C_BC] = w_c[C_PS];  opb[2*N_COMP+C_BC] = w_mz[C_PS];
        opa[2*N_COMP+C_BB] = w_pz[C_VX]; opb[2*N_COMP+C_BB] = w_c[C_VX];
        opa[2*N_COMP+C_BA] = w_c[C_VY];  opb[2*N_COMP+C_BA] = w_pz[C_VY];
        opa[2*N_COMP+C_PS] = w_pz[C_BC]; opb[2*N_COMP+C_PS] = w_c[C_BC];
        for (int t = 0; t < N_TERM; t++) begin
            dd[t]  = {opa[t][DW-1], opa[t]} - {opb[t][DW-1], opb[t]};
            // |p - q| < 2^32
            mag[t] = dd[t][DW] ? DW'(-dd[t]) : dd[t][DW-1:0];
        end
        inv[0] = r_inv_x;
        inv[1] = r_inv_y;
        inv[2] = r_inv_z;
    end

    // ---------------- stage 2: products ----------------
    logic [2*DW-1:0]       r_prod [N_TERM];
    logic [N_TERM-1:0]     r_neg;
    logic                  r_v2, r_last2;
    logic [CELL_IDX_W-1:0] r_cx2, r_cy2, r_cz2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < N_TERM; t++) begin
                r_prod[t] <= 64'(mag[t]) * 64'(inv[t / N_COMP]);
                r_neg[t]  <= dd[t][DW];
            end
            r_cx2   <= r_cx1;
            r_cy2   <= r_cy1;
            r_cz2   <= r_cz1;
            r_last2 <= r_last1;
        end
    end

    // ---------------- stage 3: round, sum, saturate ----------------
    logic [2*DW-1:0]     rnd [N_TERM];
    logic signed [50:0]  trm [N_TERM];
    logic signed [50:0]  acc [N_COMP];
    t_cell               sat;

    always_comb begin
        for (int t = 0; t < N_TERM; t++) begin
            // half away from zero on the magnitude
            rnd[t] = (r_prod[t] + 64'h8000) >> 16;
            trm[t] = r_neg[t] ? -$signed({3'b000, rnd[t][47:0]})
                              :  $signed({3'b000, rnd[t][47:0]});
        end
        for (int j = 0; j < N_COMP; j++) begin
            acc[j] = trm[j];
            if (nd >= 2'd2) acc[j] = acc[j] + trm[N_COMP + j];
            if (nd == 2'd3) acc[j] = acc[j] + trm[2*N_COMP + j];
            if (acc[j] > 51'sh7FFF_FFFF) begin
                sat[j] = 32'h7FFF_FFFF;
            end else if (acc[j] < -51'sh8000_0000) begin
                sat[j] = 32'h8000_0000;
            end else begin
                sat[j] = acc[j][DW-1:0];
            end
        end
    end

    t_cell                 r_grad;
    logic                  r_v3, r_last3;
    logic [CELL_IDX_W-1:0] r_cx3, r_cy3, r_cz3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_grad  <= sat;
            r_cx3   <= r_cx2;
            r_cy3   <= r_cy2;
            r_cz3   <= r_cz2;
            r_last3 <= r_last2;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tlast  = r_last3;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_cz3, r_cy3, r_cx3, r_grad};

    // ---------------- checks ----------------
    a_pos_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_x < sx && r_pos_y < sy && r_pos_z < sz)
        else $error("grid position outside clamped extent");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= LAST_A && r_fill <= LAST_A)
        else $error("window pointer or fill count out of range");

    a_no_emit_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !(accept && emit)) |=> !r_v1)
        else $error("stage 1 valid without an emitting cell");

endmodule
